// File: hdl/salc_pkg.sv
// ============================================================================
// salc_pkg
// Shared types, constants and helpers for the set-associative LRU write-back
// cache tag unit.
// ============================================================================
package salc_pkg;

    // Geometry of the tag store
    localparam int WAYS          = 4;
    localparam int MAX_SETS      = 256;
    localparam int WAY_W         = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W          = WAY_W + 1;
    localparam int SET_W         = 8;
    localparam int MAX_SET_BITS  = $clog2(MAX_SETS + 1) - 1;
    localparam int TAG_W         = 32;
    localparam int STAMP_W       = 32;
    localparam int CFG_W         = 5;

    // Modelled access times
    localparam logic [7:0] MISS_PENALTY = 8'd100;
    localparam logic [7:0] TIME_HIT     = 8'd1;
    localparam logic [7:0] TIME_CLEAN   = TIME_HIT + MISS_PENALTY;
    localparam logic [7:0] TIME_DIRTY   = TIME_HIT + MISS_PENALTY + MISS_PENALTY;

    typedef enum logic
    {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        OUT_HIT        = 2'd0,
        OUT_CLEAN_MISS = 2'd1,
        OUT_DIRTY_MISS = 2'd2
    } outcome_t;

    typedef enum logic [1:0]
    {
        CFG_OFFSET_BITS = 2'd0,
        CFG_SET_BITS    = 2'd1,
        CFG_WAYS_USED   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // One cache line's tag state
    typedef struct packed
    {
        logic               valid;
        logic               dirty;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } line_t;

    // One set: all ways side by side in one memory row
    typedef line_t [WAYS-1:0] row_t;

    // Request into the way selection logic
    typedef struct packed
    {
        logic               is_write;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
        logic [NW_W-1:0]    nw;
    } lookup_req_t;

    // Decision of the way selection logic
    typedef struct packed
    {
        outcome_t           outcome;
        logic [WAY_W-1:0]   way;
        logic [TAG_W-1:0]   prev_tag;
        logic               prev_valid;
        logic               prev_dirty;
        logic [STAMP_W-1:0] prev_stamp;
        logic [7:0]         access_time;
    } lookup_res_t;

    // Lowest-numbered set bit of a way vector
    function automatic logic [WAY_W-1:0] first_way(input logic [WAYS-1:0] vec);
        logic [WAY_W-1:0] w;
        w = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                w = WAY_W'(i);
            end
        end
        return w;
    endfunction

endpackage

// File: hdl/set_assoc_lru_writeback_cache_tags_unit.sv
// ============================================================================
// set_assoc_lru_writeback_cache_tags_unit
// Tag store of a set-associative write-back, write-allocate cache with LRU
// replacement: lookup, victim choice and line update per access.
// ============================================================================
// After reset the unit sweeps its row memory, one set per cycle, with busy
// high; it takes no access during that sweep. For each access the set's row
// is read from the single row memory in the cycle after start is taken, and
// the updated row is written back at the end of that cycle. The result is
// registered after that lookup cycle and appears on the output ports with done
// high for exactly one cycle; it cannot be held off by the receiver. Busy is
// low again in that same cycle, so the unit takes one access at a time and a
// new access can be taken while the result is shown. Configuration registers
// may be written whenever no access is in flight.
module set_assoc_lru_writeback_cache_tags_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Access request
    input  logic                            start,
    output logic                            busy,
    input  logic                            opcode,
    input  logic [31:0]                     address,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_addr,
    input  logic [salc_pkg::CFG_W-1:0]      cfg_wdata,
    // Result
    output logic                            done,
    output logic [1:0]                      outcome,
    output logic [7:0]                      set_index,
    output logic [31:0]                     tag,
    output logic [1:0]                      way,
    output logic [31:0]                     prev_tag,
    output logic                            prev_valid,
    output logic                            prev_dirty,
    output logic [31:0]                     prev_last_used,
    output logic [7:0]                      access_time,
    output logic [31:0]                     op_index
);
    import salc_pkg::*;

    // Configuration
    logic [4:0]         offset_bits_reg;
    logic [3:0]         set_bits_reg;
    logic [2:0]         ways_used_reg;
    logic [3:0]         sb_eff;
    logic [NW_W-1:0]    nw_eff;

    // Control
    state_t             state_reg;
    state_t             state_next;
    logic [SET_W-1:0]   clear_cnt_reg;
    logic [31:0]        access_cnt_reg;
    logic               accept;

    // Request held during lookup
    logic               is_write_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [SET_W-1:0]   set_reg;

    // Address split
    logic [31:0]        addr_shifted;
    logic [SET_W-1:0]   set_mask;
    logic [SET_W-1:0]   set_in;
    logic [5:0]         split;
    logic [TAG_W-1:0]   tag_in;

    // Memory and lookup
    logic               ram_we;
    logic [SET_W-1:0]   ram_waddr;
    row_t               ram_wdata;
    row_t               ram_rdata;
    row_t               row_next;
    lookup_req_t        lk_req;
    lookup_res_t        lk_res;

    // Result registers
    logic               done_reg;
    lookup_res_t        res_reg;
    logic [SET_W-1:0]   res_set_reg;
    logic [TAG_W-1:0]   res_tag_reg;
    logic [31:0]        res_index_reg;

    assign accept = start && !busy;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= 5'd5;
            set_bits_reg    <= 4'd8;
            ways_used_reg   <= 3'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_wdata[4:0];
                CFG_SET_BITS:    set_bits_reg    <= cfg_wdata[3:0];
                CFG_WAYS_USED:   ways_used_reg   <= cfg_wdata[2:0];
                default:         ;
            endcase
        end
    end

    // Saturate set bits and way count
    always_comb
    begin
        if (set_bits_reg > 4'(MAX_SET_BITS))
        begin
            sb_eff = 4'(MAX_SET_BITS);
        end
        else
        begin
            sb_eff = set_bits_reg;
        end
        if (ways_used_reg == 3'd0)
        begin
            nw_eff = NW_W'(1);
        end
        else if (ways_used_reg > 3'(WAYS))
        begin
            nw_eff = NW_W'(WAYS);
        end
        else
        begin
            nw_eff = NW_W'(ways_used_reg);
        end
    end

    // Split the address into set index and tag
    always_comb
    begin
        addr_shifted = address >> offset_bits_reg;
        set_mask     = SET_W'((9'd1 << sb_eff) - 9'd1);
        set_in       = addr_shifted[SET_W-1:0] & set_mask;
        split        = {1'b0, offset_bits_reg} + {2'b00, sb_eff};
        if (split >= 6'd32)
        begin
            tag_in = '0;
        end
        else
        begin
            tag_in = address >> split[4:0];
        end
    end

    // Hold the request for the lookup cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_write_reg <= (opcode == OP_WRITE);
            tag_reg      <= tag_in;
            set_reg      <= set_in;
        end
    end

    // Advance state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_cnt_reg  <= '0;
            access_cnt_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_LOOKUP);
            if (state_reg == ST_CLEAR)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            if (state_reg == ST_LOOKUP)
            begin
                access_cnt_reg <= access_cnt_reg + 32'd1;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_cnt_reg == SET_W'(MAX_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Drive memory writes and busy from the state
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = set_reg;
        ram_wdata = row_next;
        busy      = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clear_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_LOOKUP:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    salc_tag_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (set_in),
        .rdata (ram_rdata)
    );

    assign lk_req.is_write = is_write_reg;
    assign lk_req.tag      = tag_reg;
    assign lk_req.stamp    = access_cnt_reg;
    assign lk_req.nw       = nw_eff;

    salc_way_select u_sel
    (
        .row      (ram_rdata),
        .req      (lk_req),
        .res      (lk_res),
        .row_next (row_next)
    );

    // Capture the result at the end of the lookup
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOKUP)
        begin
            res_reg       <= lk_res;
            res_set_reg   <= set_reg;
            res_tag_reg   <= tag_reg;
            res_index_reg <= access_cnt_reg;
        end
    end

    assign done           = done_reg;
    assign outcome        = res_reg.outcome;
    assign set_index      = res_set_reg;
    assign tag            = res_tag_reg;
    assign way            = 2'(res_reg.way);
    assign prev_tag       = res_reg.prev_tag;
    assign prev_valid     = res_reg.prev_valid;
    assign prev_dirty     = res_reg.prev_dirty;
    assign prev_last_used = res_reg.prev_stamp;
    assign access_time    = res_reg.access_time;
    assign op_index       = res_index_reg;

    // A taken request yields its result after the lookup state
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("taken request produced no result");

    // A result only follows a lookup
    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_LOOKUP))
        else $error("result without lookup");

    // The reported way lies within the ways in use
    a_way_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, res_reg.way} < nw_eff))
        else $error("way outside ways in use");

    // A hit always reports a valid line
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res_reg.outcome == OUT_HIT) |-> res_reg.prev_valid)
        else $error("hit on invalid line");

    // A dirty miss always evicts a valid line
    a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res_reg.outcome == OUT_DIRTY_MISS) |-> res_reg.prev_valid)
        else $error("writeback of invalid line");

endmodule

// File: hdl/salc_tag_ram.sv
// ============================================================================
// salc_tag_ram
// Row memory of the tag store: one row per set holding all ways, one write
// port and one read port with registered read data.
// ============================================================================
module salc_tag_ram
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [salc_pkg::SET_W-1:0]  waddr,
    input  salc_pkg::row_t              wdata,
    input  logic [salc_pkg::SET_W-1:0]  raddr,
    output salc_pkg::row_t              rdata
);
    import salc_pkg::*;

    row_t mem_reg [MAX_SETS];
    row_t rdata_reg;

    // Write one row
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read one row, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/salc_way_select.sv
// ============================================================================
// salc_way_select
// Hit detection, victim choice (first free way, else least recently used)
// and the updated set row for one request.
// ============================================================================
module salc_way_select
(
    input  salc_pkg::row_t          row,
    input  salc_pkg::lookup_req_t   req,
    output salc_pkg::lookup_res_t   res,
    output salc_pkg::row_t          row_next
);
    import salc_pkg::*;

    logic [WAYS-1:0]  active_vec;
    logic [WAYS-1:0]  hit_vec;
    logic [WAYS-1:0]  free_vec;
    logic [WAYS-1:0]  old_vec;
    logic             hit;
    logic [WAY_W-1:0] way_sel;
    line_t            prev;

    // Compare the tag against every way in use
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            active_vec[i] = (NW_W'(i) < req.nw);
            hit_vec[i]    = active_vec[i] && row[i].valid && (row[i].tag == req.tag);
            free_vec[i]   = active_vec[i] && !row[i].valid;
        end
    end

    // Mark the oldest way: strictly older than lower ways, not newer than higher
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            old_vec[i] = active_vec[i];
            for (int j = 0; j < WAYS; j++)
            begin
                if (j < i && active_vec[j])
                begin
                    old_vec[i] = old_vec[i] && (row[i].stamp < row[j].stamp);
                end
                else if (j > i && active_vec[j])
                begin
                    old_vec[i] = old_vec[i] && (row[i].stamp <= row[j].stamp);
                end
            end
        end
    end

    // Pick the way
    always_comb
    begin
        hit = |hit_vec;
        if (hit)
        begin
            way_sel = first_way(hit_vec);
        end
        else if (|free_vec)
        begin
            way_sel = first_way(free_vec);
        end
        else
        begin
            way_sel = first_way(old_vec);
        end
        prev = row[way_sel];
    end

    // Report the previous line state and the outcome
    always_comb
    begin
        res.way        = way_sel;
        res.prev_valid = prev.valid;
        res.prev_dirty = prev.dirty;
        res.prev_tag   = prev.valid ? prev.tag   : '0;
        res.prev_stamp = prev.valid ? prev.stamp : '0;
        if (hit)
        begin
            res.outcome     = OUT_HIT;
            res.access_time = TIME_HIT;
        end
        else if (prev.dirty)
        begin
            res.outcome     = OUT_DIRTY_MISS;
            res.access_time = TIME_DIRTY;
        end
        else
        begin
            res.outcome     = OUT_CLEAN_MISS;
            res.access_time = TIME_CLEAN;
        end
    end

    // Refresh the stamp; mark the line dirty on a write hit; refill it on a miss
    always_comb
    begin
        row_next                 = row;
        row_next[way_sel].stamp  = req.stamp;
        if (hit)
        begin
            row_next[way_sel].dirty = prev.dirty || req.is_write;
        end
        else
        begin
            row_next[way_sel].valid = 1'b1;
            row_next[way_sel].tag   = req.tag;
            row_next[way_sel].dirty = req.is_write;
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU write-back cache tag unit.
// A queue of access and register-write requests feeds a clocked driver. A
// clocked monitor predicts every accepted access on a private copy of the
// tag store and compares each result strobe, field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import salc_pkg::*;

    localparam int LINES         = WAYS * MAX_SETS;
    localparam int SETTLE_CYCLES = 3;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 37;

    typedef enum logic
    {
        ACT_ACCESS,
        ACT_CONFIG
    } act_kind_t;

    // One pending request: a cache access or a register write
    typedef struct
    {
        act_kind_t   kind;
        opcode_t     op;
        logic [31:0] addr;
        cfg_index_t  reg_idx;
        logic [4:0]  value;
        int          gap_pct;
    } cache_req_t;

    // One predicted lookup result
    typedef struct packed
    {
        outcome_t    outcome;
        logic [7:0]  set_index;
        logic [31:0] tag;
        logic [1:0]  way;
        logic [31:0] prev_tag;
        logic        prev_valid;
        logic        prev_dirty;
        logic [31:0] prev_last_used;
        logic [7:0]  access_time;
        logic [31:0] op_index;
    } lookup_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [31:0] address;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [4:0]  cfg_wdata;
    logic        done;
    logic [1:0]  outcome;
    logic [7:0]  set_index;
    logic [31:0] tag;
    logic [1:0]  way;
    logic [31:0] prev_tag;
    logic        prev_valid;
    logic        prev_dirty;
    logic [31:0] prev_last_used;
    logic [7:0]  access_time;
    logic [31:0] op_index;

    cache_req_t  req_queue[$];
    lookup_t     expected_lookups[$];
    int          err_count = 0;
    int          cycle_count = 0;
    int          quiet_cycles = 0;
    bit          req_taken = 0;

    // Shadow tag store and registers
    bit          shadow_valid [LINES];
    bit          shadow_dirty [LINES];
    logic [31:0] shadow_tag [LINES];
    logic [31:0] shadow_stamp [LINES];
    logic [31:0] access_count = '0;
    logic [4:0]  cur_offset_bits = 5'd5;
    logic [3:0]  cur_set_bits = 4'd8;
    logic [2:0]  cur_ways_used = 3'd4;

    // Geometry the request generator is currently aiming at
    int unsigned gen_offset = 5;
    int unsigned gen_sets = 8;
    int unsigned gen_ways = 4;
    int          fill_gap = 0;

    set_assoc_lru_writeback_cache_tags_unit u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .address        (address),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .outcome        (outcome),
        .set_index      (set_index),
        .tag            (tag),
        .way            (way),
        .prev_tag       (prev_tag),
        .prev_valid     (prev_valid),
        .prev_dirty     (prev_dirty),
        .prev_last_used (prev_last_used),
        .access_time    (access_time),
        .op_index       (op_index)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Look up one access in the shadow store, update it, return the result
    function automatic lookup_t predict_lookup(input opcode_t op, input logic [31:0] addr);
        lookup_t     r;
        int unsigned sb;
        int unsigned nw;
        int unsigned off;
        int unsigned split;
        int unsigned base;
        int unsigned w;
        int unsigned li;
        logic [63:0] wide;
        logic [31:0] set_v;
        logic [31:0] tag_v;
        bit          hit;
        sb = (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cur_set_bits;
        nw = (cur_ways_used == 0) ? 1 : ((cur_ways_used > WAYS) ? WAYS : cur_ways_used);
        off = cur_offset_bits;
        wide = (64'(addr) >> off) & ((64'd1 << sb) - 64'd1);
        set_v = wide[31:0];
        split = off + sb;
        tag_v = (split >= 32) ? 32'd0 : (addr >> split);
        base = set_v * WAYS;

        // Search the valid ways in use
        hit = 1'b0;
        w = 0;
        for (int i = 0; i < nw; i++)
        begin
            if (!hit && shadow_valid[base + i] && shadow_tag[base + i] == tag_v)
            begin
                hit = 1'b1;
                w = i;
            end
        end

        // Pick the victim: first empty way, else the oldest stamp
        if (!hit)
        begin
            w = nw;
            for (int i = 0; i < nw; i++)
            begin
                if (w == nw && !shadow_valid[base + i])
                begin
                    w = i;
                end
            end
            if (w == nw)
            begin
                w = 0;
                for (int i = 1; i < nw; i++)
                begin
                    if (shadow_stamp[base + i] < shadow_stamp[base + w])
                    begin
                        w = i;
                    end
                end
            end
        end

        li = base + w;
        r.prev_valid = shadow_valid[li];
        r.prev_dirty = shadow_dirty[li];
        r.prev_tag = shadow_valid[li] ? shadow_tag[li] : 32'd0;
        r.prev_last_used = shadow_valid[li] ? shadow_stamp[li] : 32'd0;

        if (hit)
        begin
            r.outcome = OUT_HIT;
            r.access_time = TIME_HIT;
            if (op == OP_WRITE)
            begin
                shadow_dirty[li] = 1'b1;
            end
        end
        else
        begin
            r.outcome = r.prev_dirty ? OUT_DIRTY_MISS : OUT_CLEAN_MISS;
            r.access_time = r.prev_dirty ? TIME_DIRTY : TIME_CLEAN;
            shadow_tag[li] = tag_v;
            shadow_valid[li] = 1'b1;
            shadow_dirty[li] = (op == OP_WRITE);
        end
        shadow_stamp[li] = access_count;

        r.set_index = set_v[7:0];
        r.tag = tag_v;
        r.way = w[1:0];
        r.op_index = access_count;
        access_count = access_count + 32'd1;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            err_count++;
        end
    endtask

    task automatic queue_access(input opcode_t op, input logic [31:0] addr);
        cache_req_t r;
        r.kind = ACT_ACCESS;
        r.op = op;
        r.addr = addr;
        r.reg_idx = CFG_OFFSET_BITS;
        r.value = '0;
        r.gap_pct = fill_gap;
        req_queue.push_back(r);
    endtask

    task automatic queue_reg_write(input cfg_index_t idx, input logic [4:0] value);
        cache_req_t r;
        r.kind = ACT_CONFIG;
        r.op = OP_READ;
        r.addr = '0;
        r.reg_idx = idx;
        r.value = value;
        r.gap_pct = fill_gap;
        req_queue.push_back(r);
    endtask

    // Write all three registers and track the geometry they select
    task automatic queue_geometry(input int unsigned off, input int unsigned sb,
                                  input int unsigned nways);
        queue_reg_write(CFG_OFFSET_BITS, 5'(off));
        queue_reg_write(CFG_SET_BITS, 5'(sb));
        queue_reg_write(CFG_WAYS_USED, 5'(nways));
        gen_offset = off;
        gen_sets = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
        gen_ways = (nways == 0) ? 1 : ((nways > WAYS) ? WAYS : nways);
    endtask

    // Mostly a small pool of tags over a few sets, so hits and evictions occur
    function automatic logic [31:0] pick_address();
        logic [63:0] a;
        int unsigned split;
        split = gen_offset + gen_sets;
        if ($urandom_range(99) < 15)
        begin
            return $urandom();
        end
        a = 64'($urandom_range(gen_ways + 1)) << split;
        a |= (64'($urandom_range(3)) & ((64'd1 << gen_sets) - 64'd1)) << gen_offset;
        a |= 64'($urandom()) & ((64'd1 << gen_offset) - 64'd1);
        return a[31:0];
    endfunction

    // Cycle counter with a hard limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Track register writes, predict accepted requests, check results
    always @(posedge clk)
    begin : result_mon
        lookup_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_lookups.size() == 0)
                begin
                    $error("unexpected result, op_index %0d", op_index);
                    err_count++;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    check_field("outcome", 32'(want.outcome), 32'(outcome));
                    check_field("set_index", 32'(want.set_index), 32'(set_index));
                    check_field("tag", want.tag, tag);
                    check_field("way", 32'(want.way), 32'(way));
                    check_field("prev_tag", want.prev_tag, prev_tag);
                    check_field("prev_valid", 32'(want.prev_valid), 32'(prev_valid));
                    check_field("prev_dirty", 32'(want.prev_dirty), 32'(prev_dirty));
                    check_field("prev_last_used", want.prev_last_used, prev_last_used);
                    check_field("access_time", 32'(want.access_time), 32'(access_time));
                    check_field("op_index", want.op_index, op_index);
                end
            end
            if (start && !busy)
            begin
                expected_lookups.push_back(predict_lookup(opcode_t'(opcode), address));
                req_taken = 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_addr))
                    CFG_OFFSET_BITS: cur_offset_bits = cfg_wdata[4:0];
                    CFG_SET_BITS:    cur_set_bits = cfg_wdata[3:0];
                    CFG_WAYS_USED:   cur_ways_used = cfg_wdata[2:0];
                    default:         ;
                endcase
            end
        end
    end

    // Present requests from the queue; register writes only when quiet
    always @(negedge clk)
    begin : req_drv
        logic       next_start;
        logic       next_we;
        cache_req_t head;
        // Hold start low while in reset
        next_start = 1'b0;
        next_we = 1'b0;
        if (rst_n)
        begin
            next_start = start;

            // Retire the request taken at the last rising edge
            if (req_taken)
            begin
                req_taken = 1'b0;
                next_start = 1'b0;
                void'(req_queue.pop_front());
            end

            if (!next_start && expected_lookups.size() == 0)
            begin
                quiet_cycles++;
            end
            else
            begin
                quiet_cycles = 0;
            end

            if (!next_start && req_queue.size() != 0)
            begin
                head = req_queue[0];
                if (head.kind == ACT_ACCESS)
                begin
                    // Idle this cycle at the phase's rate
                    if ($urandom_range(99) >= head.gap_pct)
                    begin
                        next_start = 1'b1;
                        opcode <= head.op;
                        address <= head.addr;
                    end
                end
                else if (quiet_cycles >= SETTLE_CYCLES && !busy)
                begin
                    next_we = 1'b1;
                    cfg_addr <= head.reg_idx;
                    cfg_wdata <= head.value;
                    void'(req_queue.pop_front());
                end
            end
        end
        start <= next_start;
        cfg_we <= next_we;
    end

    // Stimulus, reset and end of run
    initial
    begin
        int unsigned geo [11][3];
        opcode_t     op;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = 1'b0;
        address = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;

        // Directed: fill one set, evict clean and dirty lines, address extremes
        queue_access(OP_READ, 32'h0000_2000);
        queue_access(OP_READ, 32'h0000_201F);
        queue_access(OP_WRITE, 32'h0000_2000);
        queue_access(OP_READ, 32'h0000_4000);
        queue_access(OP_WRITE, 32'h0000_6000);
        queue_access(OP_READ, 32'h0000_8000);
        queue_access(OP_READ, 32'h0000_A000);
        queue_access(OP_WRITE, 32'h0000_C000);
        queue_access(OP_READ, 32'h0000_6004);
        queue_access(OP_READ, 32'hFFFF_FFFF);
        queue_access(OP_WRITE, 32'hFFFF_FFFF);
        queue_access(OP_READ, 32'h0000_0000);
        queue_access(OP_WRITE, 32'h8000_0000);
        // Way count of zero acts as one way
        queue_geometry(5, 8, 0);
        queue_access(OP_WRITE, 32'h0000_E000);
        queue_access(OP_READ, 32'h0000_E010);
        // Way count above the maximum saturates; old lines come back into view
        queue_geometry(5, 8, 7);
        queue_access(OP_READ, 32'h0000_C000);
        // Too many sets saturates
        queue_geometry(5, 15, 4);
        queue_access(OP_READ, 32'h0000_C000);
        // Wide split: tag drops to zero
        queue_geometry(31, 8, 4);
        queue_access(OP_READ, 32'h8000_0000);
        queue_access(OP_READ, 32'h0000_0000);
        queue_geometry(24, 8, 4);
        queue_access(OP_READ, 32'hFF00_0000);
        queue_access(OP_WRITE, 32'hFF12_3456);

        // Random: several geometries, each through the idle phases
        geo = '{'{5, 8, 4}, '{0, 0, 1}, '{0, 8, 4}, '{31, 15, 7}, '{2, 3, 2},
                '{4, 2, 3}, '{24, 8, 4}, '{12, 5, 0}, '{7, 1, 4}, '{20, 10, 4},
                '{3, 6, 5}};
        for (int g = 0; g < 11; g++)
        begin
            fill_gap = 0;
            queue_geometry(geo[g][0], geo[g][1], geo[g][2]);
            for (int p = 0; p < 3; p++)
            begin
                fill_gap = (p == 0) ? 0 : ((p == 1) ? 65 : 28);
                for (int n = 0; n < PHASE_ITEMS; n++)
                begin
                    op = ($urandom_range(1) == 1) ? OP_WRITE : OP_READ;
                    queue_access(op, pick_address());
                end
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain, then hold for stray results
        while (req_queue.size() != 0 || start || expected_lookups.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: set_assoc_lru_writeback_cache_tags_unit.f
hdl/salc_pkg.sv
hdl/salc_tag_ram.sv
hdl/salc_way_select.sv
hdl/set_assoc_lru_writeback_cache_tags_unit.sv
tb/tb.sv
